// File: rtl/t16alu_pkg.sv
package t16alu_pkg;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_ADDSUB3,
        CLS_SHIFT_IMM,
        CLS_IMM8,
        CLS_ALU_REG,
        CLS_EXTEND,
        CLS_REVERSE
    } cls_t;

    localparam logic [3:0] FLAG_N = 4'd8;
    localparam logic [3:0] FLAG_Z = 4'd4;
    localparam logic [3:0] FLAG_C = 4'd2;
    localparam logic [3:0] FLAG_V = 4'd1;

    localparam logic [3:0] ALU_AND = 4'd0;
    localparam logic [3:0] ALU_EOR = 4'd1;
    localparam logic [3:0] ALU_LSL = 4'd2;
    localparam logic [3:0] ALU_LSR = 4'd3;
    localparam logic [3:0] ALU_ASR = 4'd4;
    localparam logic [3:0] ALU_ADC = 4'd5;
    localparam logic [3:0] ALU_SBC = 4'd6;
    localparam logic [3:0] ALU_ROR = 4'd7;
    localparam logic [3:0] ALU_TST = 4'd8;
    localparam logic [3:0] ALU_RSB = 4'd9;
    localparam logic [3:0] ALU_CMP = 4'd10;
    localparam logic [3:0] ALU_CMN = 4'd11;
    localparam logic [3:0] ALU_ORR = 4'd12;
    localparam logic [3:0] ALU_MUL = 4'd13;
    localparam logic [3:0] ALU_BIC = 4'd14;
    localparam logic [3:0] ALU_MVN = 4'd15;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam logic [1:0] IMM_MOV = 2'd0;
    localparam logic [1:0] IMM_CMP = 2'd1;
    localparam logic [1:0] IMM_ADD = 2'd2;
    localparam logic [1:0] IMM_SUB = 2'd3;

    localparam logic [1:0] EXT_SXTH = 2'd0;
    localparam logic [1:0] EXT_SXTB = 2'd1;
    localparam logic [1:0] EXT_UXTH = 2'd2;
    localparam logic [1:0] EXT_UXTB = 2'd3;

    localparam logic [1:0] REV_REV   = 2'd0;
    localparam logic [1:0] REV_REV16 = 2'd1;
    localparam logic [1:0] REV_RSVD  = 2'd2;
    localparam logic [1:0] REV_REVSH = 2'd3;

    typedef struct packed {
        cls_t        cls;
        logic [15:0] instruction;
    } dec_item_t;

endpackage

// File: rtl/t16alu_decode.sv
module t16alu_decode
    import t16alu_pkg::*;
(
    input  logic [15:0] instruction,
    output dec_item_t   item
);

    cls_t cls;

    always_comb
    begin
        if ((instruction & 16'he000) == 16'h0000)
        begin
            if ((instruction & 16'h1800) == 16'h1800)
                cls = CLS_ADDSUB3;
            else
                cls = CLS_SHIFT_IMM;
        end
        else if ((instruction & 16'he000) == 16'h2000)
            cls = CLS_IMM8;
        else if ((instruction & 16'hfc00) == 16'h4000)
            cls = CLS_ALU_REG;
        else if ((instruction & 16'hff00) == 16'hb200)
            cls = CLS_EXTEND;
        else if ((instruction & 16'hff00) == 16'hba00 && instruction[7:6] != REV_RSVD)
            cls = CLS_REVERSE;
        else
            cls = CLS_NONE;
    end

    assign item.cls = cls;
    assign item.instruction = instruction;

endmodule

// File: rtl/t16alu_queue.sv
module t16alu_queue
    import t16alu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  dec_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output dec_item_t head
);

    dec_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: rtl/t16alu_exec.sv
module t16alu_exec
    import t16alu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  dec_item_t   item,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        write_enable,
    output logic [2:0]  dest_index,
    output logic [31:0] write_value,
    output logic [3:0]  flags_nzcv,
    output logic        not_handled
);

    logic [31:0] regs_reg [8];
    logic [3:0]  flags_reg;
    logic        valid_reg;
    logic        we_reg;
    logic [2:0]  d_reg;
    logic [31:0] val_reg;
    logic [3:0]  fl_reg;
    logic        nh_reg;

    logic [15:0] ins;
    logic [2:0]  rd;
    logic [2:0]  rs;
    logic [2:0]  rm;
    logic [31:0] a_op;
    logic [31:0] b_op;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic        add_cin;
    logic [32:0] add_sum;
    logic [31:0] add_r;
    logic [3:0]  sum_nzcv;
    logic [31:0] sh_in;
    logic [1:0]  sh_type;
    logic [7:0]  sh_n;
    logic [31:0] sh_r;
    logic        sh_c;
    logic [31:0] mul_r;
    logic [31:0] val;
    logic        we;
    logic        nh;
    logic [2:0]  d;
    logic [3:0]  fl;
    logic        take;
    logic [15:0] rev_h;
    logic [63:0] ror_w;

    assign ins = item.instruction;
    assign rd = (item.cls == CLS_IMM8) ? ins[10:8] : ins[2:0];
    assign rs = ins[5:3];
    assign rm = ins[8:6];
    assign a_op = regs_reg[rd];
    assign b_op = regs_reg[rs];
    assign mul_r = a_op * b_op;

    assign in_ready = !valid_reg || out_ready;
    assign take = in_valid && in_ready;

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
    assign add_r = add_sum[31:0];
    assign sum_nzcv = {add_r[31], add_r == 32'd0, add_sum[32],
                       (~(add_a[31] ^ add_b[31])) & (add_a[31] ^ add_r[31])};

    // Shift_C over amounts 0..255
    always_comb
    begin
        sh_r = sh_in;
        sh_c = flags_reg[1];
        ror_w = {sh_in, sh_in} >> sh_n[4:0];
        if (sh_n != 8'd0)
        begin
            case (sh_type)
                SH_LSL:
                begin
                    if (sh_n < 8'd32)
                    begin
                        sh_r = sh_in << sh_n[4:0];
                        sh_c = sh_in[5'd0 - sh_n[4:0]];
                    end
                    else
                    begin
                        sh_r = 32'd0;
                        sh_c = (sh_n == 8'd32) ? sh_in[0] : 1'b0;
                    end
                end
                SH_LSR:
                begin
                    if (sh_n < 8'd32)
                    begin
                        sh_r = sh_in >> sh_n[4:0];
                        sh_c = sh_in[sh_n[4:0] - 5'd1];
                    end
                    else
                    begin
                        sh_r = 32'd0;
                        sh_c = (sh_n == 8'd32) ? sh_in[31] : 1'b0;
                    end
                end
                SH_ASR:
                begin
                    if (sh_n < 8'd32)
                    begin
                        sh_r = $unsigned($signed(sh_in) >>> sh_n[4:0]);
                        sh_c = sh_in[sh_n[4:0] - 5'd1];
                    end
                    else
                    begin
                        sh_r = {32{sh_in[31]}};
                        sh_c = sh_in[31];
                    end
                end
                default:
                begin
                    sh_r = ror_w[31:0];
                    sh_c = ror_w[31];
                end
            endcase
        end
    end

    always_comb
    begin
        add_a = a_op;
        add_b = b_op;
        add_cin = 1'b0;
        sh_in = b_op;
        sh_type = ins[12:11];
        sh_n = {3'd0, ins[10:6]};
        val = 32'd0;
        we = 1'b0;
        nh = 1'b0;
        d = rd;
        fl = flags_reg;
        rev_h = {b_op[7:0], b_op[15:8]};
        case (item.cls)
            CLS_ADDSUB3:
            begin
                add_a = b_op;
                add_b = ins[10] ? {29'd0, rm} : regs_reg[rm];
                if (ins[9])
                begin
                    add_b = ~add_b;
                    add_cin = 1'b1;
                end
                val = add_r;
                fl = sum_nzcv;
                we = 1'b1;
            end
            CLS_SHIFT_IMM:
            begin
                if (ins[10:6] == 5'd0 && ins[12:11] != SH_LSL)
                    sh_n = 8'd32;
                val = sh_r;
                fl = {sh_r[31], sh_r == 32'd0, sh_c, flags_reg[0]};
                we = 1'b1;
            end
            CLS_IMM8:
            begin
                add_b = {24'd0, ins[7:0]};
                if (ins[12:11] == IMM_CMP || ins[12:11] == IMM_SUB)
                begin
                    add_b = ~add_b;
                    add_cin = 1'b1;
                end
                if (ins[12:11] == IMM_MOV)
                begin
                    val = {24'd0, ins[7:0]};
                    fl = {1'b0, ins[7:0] == 8'd0, flags_reg[1:0]};
                    we = 1'b1;
                end
                else
                begin
                    val = add_r;
                    fl = sum_nzcv;
                    we = (ins[12:11] != IMM_CMP);
                end
            end
            CLS_ALU_REG:
            begin
                sh_in = a_op;
                sh_n = b_op[7:0];
                we = 1'b1;
                case (ins[9:6])
                    ALU_AND, ALU_TST: val = a_op & b_op;
                    ALU_EOR: val = a_op ^ b_op;
                    ALU_ORR: val = a_op | b_op;
                    ALU_MUL: val = mul_r;
                    ALU_BIC: val = a_op & ~b_op;
                    ALU_MVN: val = ~b_op;
                    ALU_LSL: sh_type = SH_LSL;
                    ALU_LSR: sh_type = SH_LSR;
                    ALU_ASR: sh_type = SH_ASR;
                    ALU_ROR: sh_type = SH_ROR;
                    ALU_ADC: add_cin = flags_reg[1];
                    ALU_SBC:
                    begin
                        add_b = ~b_op;
                        add_cin = flags_reg[1];
                    end
                    ALU_RSB:
                    begin
                        add_a = 32'd0;
                        add_b = ~b_op;
                        add_cin = 1'b1;
                    end
                    ALU_CMP:
                    begin
                        add_b = ~b_op;
                        add_cin = 1'b1;
                    end
                    default: add_cin = 1'b0;
                endcase
                case (ins[9:6])
                    ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR:
                    begin
                        val = sh_r;
                        fl = {sh_r[31], sh_r == 32'd0, sh_c, flags_reg[0]};
                    end
                    ALU_ADC, ALU_SBC, ALU_RSB, ALU_CMP, ALU_CMN:
                    begin
                        val = add_r;
                        fl = sum_nzcv;
                    end
                    default: fl = {val[31], val == 32'd0, flags_reg[1:0]};
                endcase
                if (ins[9:6] == ALU_TST || ins[9:6] == ALU_CMP || ins[9:6] == ALU_CMN)
                    we = 1'b0;
            end
            CLS_EXTEND:
            begin
                case (ins[7:6])
                    EXT_SXTH: val = {{16{b_op[15]}}, b_op[15:0]};
                    EXT_SXTB: val = {{24{b_op[7]}}, b_op[7:0]};
                    EXT_UXTH: val = {16'd0, b_op[15:0]};
                    default: val = {24'd0, b_op[7:0]};
                endcase
                we = 1'b1;
            end
            CLS_REVERSE:
            begin
                case (ins[7:6])
                    REV_REV: val = {b_op[7:0], b_op[15:8], b_op[23:16], b_op[31:24]};
                    REV_REV16: val = {b_op[23:16], b_op[31:24], b_op[7:0], b_op[15:8]};
                    default: val = {{16{rev_h[15]}}, rev_h};
                endcase
                we = 1'b1;
            end
            default: nh = 1'b1;
        endcase
        if (!we)
        begin
            d = 3'd0;
            val = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                regs_reg[i] <= 32'd0;
            flags_reg <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                if (we)
                    regs_reg[d] <= val;
                flags_reg <= fl;
            end
            if (in_ready)
                valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            we_reg  <= we;
            d_reg   <= d;
            val_reg <= val;
            fl_reg  <= fl;
            nh_reg  <= nh;
        end
    end

    assign out_valid = valid_reg;
    assign write_enable = we_reg;
    assign dest_index = d_reg;
    assign write_value = val_reg;
    assign flags_nzcv = fl_reg;
    assign not_handled = nh_reg;

endmodule

// File: rtl/thumb16_alu_execute.sv
// Thumb-16 data-processing execute block.
// Input channel: instruction with in_valid/in_ready, one 16-bit encoding per beat.
// Output channel: out_valid/out_ready with write_enable, dest_index, write_value,
// flags_nzcv and not_handled; exactly one result beat per input beat, in order.
// The front decodes the instruction class and pushes it into a two-entry queue;
// the back reads the low registers and flags, executes and writes back in the
// same cycle, so dependent instructions follow each other with no bubble.
// Throughput is one instruction per cycle when the receiver does not stall; each
// instruction passes through the queue and then the result register.
// When the receiver stalls the result register holds, the queue fills, and
// in_ready drops once both queue entries are taken.
// Reset clears all eight registers and the flags to zero and empties the queue.
module thumb16_alu_execute
    import t16alu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] instruction,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        write_enable,
    output logic [2:0]  dest_index,
    output logic [31:0] write_value,
    output logic [3:0]  flags_nzcv,
    output logic        not_handled
);

    dec_item_t dec_item;
    dec_item_t head;
    logic      q_full;
    logic      q_nempty;
    logic      ex_ready;
    logic      q_pop;

    t16alu_decode u_decode (
        .instruction (instruction),
        .item        (dec_item)
    );

    assign in_ready = !q_full;
    assign q_pop = q_nempty && ex_ready;

    t16alu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_item (dec_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_nempty),
        .head      (head)
    );

    t16alu_exec u_exec (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (q_nempty),
        .item         (head),
        .in_ready     (ex_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .write_enable (write_enable),
        .dest_index   (dest_index),
        .write_value  (write_value),
        .flags_nzcv   (flags_nzcv),
        .not_handled  (not_handled)
    );

    a_nh_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && not_handled |-> !write_enable)
        else $error("not handled result writes a register");

    a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |-> dest_index == 3'd0 && write_value == 32'd0)
        else $error("idle write fields not zero");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(write_value))
        else $error("stalled result changed");

endmodule
